### rtl/mbp_pkg.sv
// Package: shared types and constants of the MIDI byte parser.
package mbp_pkg;

	// Event kinds on the output channel
	localparam logic [2:0] KIND_NOTE_ON  = 3'd0;
	localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
	localparam logic [2:0] KIND_CC       = 3'd2;
	localparam logic [2:0] KIND_CLOCK    = 3'd3;
	localparam logic [2:0] KIND_START    = 3'd4;
	localparam logic [2:0] KIND_STOP     = 3'd5;

	// Status bytes and status nibbles
	localparam logic [7:0] ST_CLOCK       = 8'hF8;
	localparam logic [7:0] ST_START       = 8'hFA;
	localparam logic [7:0] ST_STOP        = 8'hFC;
	localparam logic [7:0] ST_SYSEX       = 8'hF0;
	localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
	localparam logic [7:0] ST_NONE        = 8'h00;
	localparam logic [3:0] HI_NOTE_OFF    = 4'h8;
	localparam logic [3:0] HI_NOTE_ON     = 4'h9;
	localparam logic [3:0] HI_CC          = 4'hB;
	localparam logic [3:0] HI_PROG_CHANGE = 4'hC;
	localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;
	localparam logic [3:0] HI_SYSTEM      = 4'hF;
	localparam logic [4:0] RT_PREFIX      = 5'b11111;

	localparam logic [4:0] CHAN_RT = 5'd1;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [4:0] channel;
		logic [6:0] data_first;
		logic [6:0] data_second;
	} evt_t;

	typedef struct packed {
		logic valid;
		evt_t evt;
	} dec_res_t;

endpackage

### rtl/mbp_if.sv
// Interfaces: received byte channel and event channel.
interface mbp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface mbp_ev_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_kind;
	logic [4:0] channel;
	logic [6:0] data_first;
	logic [6:0] data_second;

	modport source (output valid, output event_kind, output channel, output data_first,
		output data_second, input ready);
	modport sink (input valid, input event_kind, input channel, input data_first,
		input data_second, output ready);
endinterface

### rtl/mbp_decode.sv
// Decoder: parse state registers and the per-byte decode logic.
module mbp_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte,
	output mbp_pkg::dec_res_t  res
);

	logic [7:0] cur_status_q, run_status_q;
	logic       sysex_q, cnt_q;
	logic [6:0] first_q;

	logic [7:0] cur_status_d, run_status_d;
	logic       sysex_d, cnt_d;
	logic       first_we;
	logic [7:0] eff_status;
	logic [3:0] hi;
	logic [4:0] chan;

	always_comb begin
		cur_status_d = cur_status_q;
		run_status_d = run_status_q;
		sysex_d      = sysex_q;
		cnt_d        = cnt_q;
		first_we     = 1'b0;
		eff_status   = cur_status_q;
		hi           = cur_status_q[7:4];
		chan         = {1'b0, cur_status_q[3:0]} + 5'd1;
		res          = '0;

		if (rx_byte[7]) begin
			if (rx_byte[7:3] == mbp_pkg::RT_PREFIX) begin
				// real-time: event only, state untouched
				res.evt.channel = mbp_pkg::CHAN_RT;
				case (rx_byte)
					mbp_pkg::ST_CLOCK: begin
						res.valid          = 1'b1;
						res.evt.event_kind = mbp_pkg::KIND_CLOCK;
					end
					mbp_pkg::ST_START: begin
						res.valid          = 1'b1;
						res.evt.event_kind = mbp_pkg::KIND_START;
					end
					mbp_pkg::ST_STOP: begin
						res.valid          = 1'b1;
						res.evt.event_kind = mbp_pkg::KIND_STOP;
					end
					default: res.valid = 1'b0;
				endcase
			end else begin
				// any other status ends sysex; F7 included
				cur_status_d = rx_byte;
				cnt_d        = 1'b0;
				sysex_d      = (rx_byte == mbp_pkg::ST_SYSEX);
				if (rx_byte[7:4] != mbp_pkg::HI_SYSTEM)
					run_status_d = rx_byte;
			end
		end else if (!sysex_q &&
			!(cur_status_q == mbp_pkg::ST_NONE && run_status_q == mbp_pkg::ST_NONE)) begin
			logic cnt_eff;
			cnt_eff = cnt_q;
			if (cur_status_q == mbp_pkg::ST_NONE) begin
				eff_status   = run_status_q;
				cur_status_d = run_status_q;
				cnt_eff      = 1'b0;
			end
			hi   = eff_status[7:4];
			chan = {1'b0, eff_status[3:0]} + 5'd1;
			if (hi == mbp_pkg::HI_PROG_CHANGE || hi == mbp_pkg::HI_CHAN_PRESS) begin
				cnt_d = 1'b0;
			end else if (!cnt_eff) begin
				first_we = 1'b1;
				cnt_d    = 1'b1;
			end else begin
				cnt_d                = 1'b0;
				res.evt.channel      = chan;
				res.evt.data_first   = first_q;
				res.evt.data_second  = rx_byte[6:0];
				case (hi)
					mbp_pkg::HI_NOTE_ON: begin
						res.valid          = 1'b1;
						res.evt.event_kind = (rx_byte[6:0] == 7'd0) ?
							mbp_pkg::KIND_NOTE_OFF : mbp_pkg::KIND_NOTE_ON;
					end
					mbp_pkg::HI_NOTE_OFF: begin
						res.valid          = 1'b1;
						res.evt.event_kind = mbp_pkg::KIND_NOTE_OFF;
					end
					mbp_pkg::HI_CC: begin
						res.valid          = 1'b1;
						res.evt.event_kind = mbp_pkg::KIND_CC;
					end
					default: res.valid = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_status_q <= mbp_pkg::ST_NONE;
			run_status_q <= mbp_pkg::ST_NONE;
			sysex_q      <= 1'b0;
			cnt_q        <= 1'b0;
		end else if (step) begin
			cur_status_q <= cur_status_d;
			run_status_q <= run_status_d;
			sysex_q      <= sysex_d;
			cnt_q        <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && first_we)
			first_q <= rx_byte[6:0];
	end

endmodule

### rtl/mbp_out_stage.sv
// Result register: holds one event word until the sink takes it.
module mbp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  mbp_pkg::dec_res_t res,
	output logic              take,
	mbp_ev_if.source          ev
);

	logic          valid_q;
	mbp_pkg::evt_t evt_q;

	assign take = !valid_q || ev.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid)
			evt_q <= res.evt;
	end

	assign ev.valid       = valid_q;
	assign ev.event_kind  = evt_q.event_kind;
	assign ev.channel     = evt_q.channel;
	assign ev.data_first  = evt_q.data_first;
	assign ev.data_second = evt_q.data_second;

endmodule

### rtl/midi_byte_parser_core.sv
// Top level: MIDI byte stream parser with running status.
//
// channel | dir | words                     | payload
// rx      | in  | one received MIDI byte    | rx_byte[7:0]
// ev      | out | one decoded event, or none | event_kind, channel, data_first, data_second
//
// One byte accepted per cycle while the output does not stall; an event passes
// through the input register, then decode into the result register.
// The result register and the input register both stall only while the
// event sink holds ready low with an event pending.
// Reset clears the parse state; no status is known until one arrives.
module midi_byte_parser_core (
	input logic      clk,
	input logic      arst_n,
	mbp_rx_if.sink   rx,
	mbp_ev_if.source ev
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              take, step;
	mbp_pkg::dec_res_t res;

	assign step     = valid_s1 && take;
	assign rx.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid)
			byte_s1 <= rx.rx_byte;
	end

	mbp_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.res     (res)
	);

	mbp_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.res    (res),
		.take   (take),
		.ev     (ev)
	);

endmodule

### rtl/mbp_checker.sv
// Checker: port-level properties of the parser, bound to the top level.
module mbp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_valid,
	input logic       rx_ready,
	input logic [7:0] rx_byte,
	input logic       ev_valid,
	input logic       ev_ready,
	input logic [2:0] event_kind,
	input logic [4:0] channel,
	input logic [6:0] data_first,
	input logic [6:0] data_second
);

	// pending event holds until taken
	a_ev_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && !ev_ready |=> ev_valid && $stable(event_kind) && $stable(channel) &&
		$stable(data_first) && $stable(data_second))
		else $error("event word changed while stalled");

	// clock byte gives a clock event through the input and result registers when the sink is free
	a_clock_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_valid && rx_ready && rx_byte == mbp_pkg::ST_CLOCK) ##1 ev_ready |=>
		ev_valid && event_kind == mbp_pkg::KIND_CLOCK)
		else $error("clock byte did not give a clock event");

	// a status byte that is not real-time never produces an event
	a_status_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_valid && rx_ready && rx_byte[7] && rx_byte[7:3] != mbp_pkg::RT_PREFIX)
		##1 ev_ready |=> !ev_valid)
		else $error("status byte produced an event");

	// real-time events carry fixed fields, channel events a valid channel
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid |-> ((event_kind == mbp_pkg::KIND_CLOCK ||
		event_kind == mbp_pkg::KIND_START || event_kind == mbp_pkg::KIND_STOP) &&
		channel == mbp_pkg::CHAN_RT && data_first == 7'd0 && data_second == 7'd0) ||
		((event_kind == mbp_pkg::KIND_NOTE_ON || event_kind == mbp_pkg::KIND_NOTE_OFF ||
		event_kind == mbp_pkg::KIND_CC) && channel != 5'd0 && channel[4] == 1'b0) ||
		(channel == 5'd16 && (event_kind == mbp_pkg::KIND_NOTE_ON ||
		event_kind == mbp_pkg::KIND_NOTE_OFF || event_kind == mbp_pkg::KIND_CC)))
		else $error("event fields out of range");

endmodule

bind midi_byte_parser_core mbp_checker u_mbp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rx_valid    (rx.valid),
	.rx_ready    (rx.ready),
	.rx_byte     (rx.rx_byte),
	.ev_valid    (ev.valid),
	.ev_ready    (ev.ready),
	.event_kind  (ev.event_kind),
	.channel     (ev.channel),
	.data_first  (ev.data_first),
	.data_second (ev.data_second)
);
